// ===== sv/cia_pkg.sv =====
// ----------------------------------------------------------------------------
// cia_pkg
// Shared widths, operation codes, control word layout and the microcode
// program of the complex integer ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int WIDE_WIDTH = PROD_WIDTH + 1;
    localparam int CNT_WIDTH  = $clog2(PROD_WIDTH + 1);
    localparam int UPC_WIDTH  = 5;

    // operation codes on s_op
    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_CONJ = 3'd5;
    localparam logic [2:0] OP_CMP  = 3'd6;

    // multiplier operand pair
    localparam logic [2:0] MS_AC = 3'd0;
    localparam logic [2:0] MS_BD = 3'd1;
    localparam logic [2:0] MS_AD = 3'd2;
    localparam logic [2:0] MS_BC = 3'd3;
    localparam logic [2:0] MS_CC = 3'd4;
    localparam logic [2:0] MS_DD = 3'd5;

    // wide accumulator destination and mode
    localparam logic [1:0] AD_NONE = 2'd0;
    localparam logic [1:0] AD_DEN  = 2'd1;
    localparam logic [1:0] AD_NRE  = 2'd2;
    localparam logic [1:0] AD_NIM  = 2'd3;

    localparam logic [1:0] AM_LOAD = 2'd0;
    localparam logic [1:0] AM_ADD  = 2'd1;
    localparam logic [1:0] AM_SUB  = 2'd2;

    // accumulator write-back select
    localparam logic [2:0] WB_NONE = 3'd0;
    localparam logic [2:0] WB_LOAD = 3'd1;
    localparam logic [2:0] WB_ADD  = 3'd2;
    localparam logic [2:0] WB_SUB  = 3'd3;
    localparam logic [2:0] WB_CONJ = 3'd4;
    localparam logic [2:0] WB_MUL  = 3'd5;
    localparam logic [2:0] WB_DIV  = 3'd6;
    localparam logic [2:0] WB_ERR  = 3'd7;

    // sequencing
    localparam logic [1:0] SQ_NEXT  = 2'd0;
    localparam logic [1:0] SQ_END   = 2'd1;
    localparam logic [1:0] SQ_LOOP  = 2'd2;
    localparam logic [1:0] SQ_JZERO = 2'd3;

    // microcode addresses
    localparam logic [UPC_WIDTH-1:0] UA_LOAD  = 5'd0;
    localparam logic [UPC_WIDTH-1:0] UA_ADD   = 5'd1;
    localparam logic [UPC_WIDTH-1:0] UA_SUB   = 5'd2;
    localparam logic [UPC_WIDTH-1:0] UA_CONJ  = 5'd3;
    localparam logic [UPC_WIDTH-1:0] UA_CMP   = 5'd4;
    localparam logic [UPC_WIDTH-1:0] UA_MUL0  = 5'd5;
    localparam logic [UPC_WIDTH-1:0] UA_MUL1  = 5'd6;
    localparam logic [UPC_WIDTH-1:0] UA_MUL2  = 5'd7;
    localparam logic [UPC_WIDTH-1:0] UA_MUL3  = 5'd8;
    localparam logic [UPC_WIDTH-1:0] UA_MUL4  = 5'd9;
    localparam logic [UPC_WIDTH-1:0] UA_MUL5  = 5'd10;
    localparam logic [UPC_WIDTH-1:0] UA_DIV0  = 5'd11;
    localparam logic [UPC_WIDTH-1:0] UA_DIV1  = 5'd12;
    localparam logic [UPC_WIDTH-1:0] UA_DIV2  = 5'd13;
    localparam logic [UPC_WIDTH-1:0] UA_DIV3  = 5'd14;
    localparam logic [UPC_WIDTH-1:0] UA_DIV4  = 5'd15;
    localparam logic [UPC_WIDTH-1:0] UA_DIV5  = 5'd16;
    localparam logic [UPC_WIDTH-1:0] UA_DIV6  = 5'd17;
    localparam logic [UPC_WIDTH-1:0] UA_DINIT = 5'd18;
    localparam logic [UPC_WIDTH-1:0] UA_DSTEP = 5'd19;
    localparam logic [UPC_WIDTH-1:0] UA_DWB   = 5'd20;
    localparam logic [UPC_WIDTH-1:0] UA_DERR  = 5'd21;

    typedef struct packed {
        logic [2:0]           mul_sel;
        logic [1:0]           acc_dst;
        logic [1:0]           acc_mode;
        logic                 div_init;
        logic                 div_step;
        logic [2:0]           wb_sel;
        logic [1:0]           seq;
        logic [UPC_WIDTH-1:0] target;
    } cia_uword_t;

    // sequencer to datapath
    typedef struct packed {
        logic       take;
        logic       run;
        logic       commit;
        cia_uword_t uw;
    } cia_ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic div_zero;
    } cia_stat_t;

    function automatic cia_uword_t cia_mk(
        input logic [2:0]           mul_sel,
        input logic [1:0]           acc_dst,
        input logic [1:0]           acc_mode,
        input logic                 div_init,
        input logic                 div_step,
        input logic [2:0]           wb_sel,
        input logic [1:0]           seq,
        input logic [UPC_WIDTH-1:0] target
    );
        cia_uword_t w;
        w.mul_sel  = mul_sel;
        w.acc_dst  = acc_dst;
        w.acc_mode = acc_mode;
        w.div_init = div_init;
        w.div_step = div_step;
        w.wb_sel   = wb_sel;
        w.seq      = seq;
        w.target   = target;
        return w;
    endfunction

    // microcode program
    function automatic cia_uword_t cia_ucode(input logic [UPC_WIDTH-1:0] addr);
        cia_uword_t w;
        unique case (addr)
            UA_LOAD:  w = cia_mk(MS_AC, AD_NONE, AM_LOAD, 1'b0, 1'b0, WB_LOAD, SQ_END, UA_LOAD);
            UA_ADD:   w = cia_mk(MS_AC, AD_NONE, AM_LOAD, 1'b0, 1'b0, WB_ADD,  SQ_END, UA_LOAD);
            UA_SUB:   w = cia_mk(MS_AC, AD_NONE, AM_LOAD, 1'b0, 1'b0, WB_SUB,  SQ_END, UA_LOAD);
            UA_CONJ:  w = cia_mk(MS_AC, AD_NONE, AM_LOAD, 1'b0, 1'b0, WB_CONJ, SQ_END, UA_LOAD);
            UA_CMP:   w = cia_mk(MS_AC, AD_NONE, AM_LOAD, 1'b0, 1'b0, WB_NONE, SQ_END, UA_LOAD);
            // multiply: re = ac - bd, im = ad + bc
            UA_MUL0:  w = cia_mk(MS_AC, AD_NONE, AM_LOAD, 1'b0, 1'b0, WB_NONE, SQ_NEXT, UA_LOAD);
            UA_MUL1:  w = cia_mk(MS_BD, AD_NRE,  AM_LOAD, 1'b0, 1'b0, WB_NONE, SQ_NEXT, UA_LOAD);
            UA_MUL2:  w = cia_mk(MS_AD, AD_NRE,  AM_SUB,  1'b0, 1'b0, WB_NONE, SQ_NEXT, UA_LOAD);
            UA_MUL3:  w = cia_mk(MS_BC, AD_NIM,  AM_LOAD, 1'b0, 1'b0, WB_NONE, SQ_NEXT, UA_LOAD);
            UA_MUL4:  w = cia_mk(MS_AC, AD_NIM,  AM_ADD,  1'b0, 1'b0, WB_NONE, SQ_NEXT, UA_LOAD);
            UA_MUL5:  w = cia_mk(MS_AC, AD_NONE, AM_LOAD, 1'b0, 1'b0, WB_MUL,  SQ_END,  UA_LOAD);
            // divide: den = cc + dd, re = (ac + bd) / den, im = (bc - ad) / den
            UA_DIV0:  w = cia_mk(MS_CC, AD_NONE, AM_LOAD, 1'b0, 1'b0, WB_NONE, SQ_JZERO, UA_DERR);
            UA_DIV1:  w = cia_mk(MS_DD, AD_DEN,  AM_LOAD, 1'b0, 1'b0, WB_NONE, SQ_NEXT, UA_LOAD);
            UA_DIV2:  w = cia_mk(MS_AC, AD_DEN,  AM_ADD,  1'b0, 1'b0, WB_NONE, SQ_NEXT, UA_LOAD);
            UA_DIV3:  w = cia_mk(MS_BD, AD_NRE,  AM_LOAD, 1'b0, 1'b0, WB_NONE, SQ_NEXT, UA_LOAD);
            UA_DIV4:  w = cia_mk(MS_BC, AD_NRE,  AM_ADD,  1'b0, 1'b0, WB_NONE, SQ_NEXT, UA_LOAD);
            UA_DIV5:  w = cia_mk(MS_AD, AD_NIM,  AM_LOAD, 1'b0, 1'b0, WB_NONE, SQ_NEXT, UA_LOAD);
            UA_DIV6:  w = cia_mk(MS_AC, AD_NIM,  AM_SUB,  1'b0, 1'b0, WB_NONE, SQ_NEXT, UA_LOAD);
            UA_DINIT: w = cia_mk(MS_AC, AD_NONE, AM_LOAD, 1'b1, 1'b0, WB_NONE, SQ_NEXT, UA_LOAD);
            UA_DSTEP: w = cia_mk(MS_AC, AD_NONE, AM_LOAD, 1'b0, 1'b1, WB_NONE, SQ_LOOP, UA_LOAD);
            UA_DWB:   w = cia_mk(MS_AC, AD_NONE, AM_LOAD, 1'b0, 1'b0, WB_DIV,  SQ_END,  UA_LOAD);
            UA_DERR:  w = cia_mk(MS_AC, AD_NONE, AM_LOAD, 1'b0, 1'b0, WB_ERR,  SQ_END,  UA_LOAD);
            default:  w = cia_mk(MS_AC, AD_NONE, AM_LOAD, 1'b0, 1'b0, WB_NONE, SQ_END,  UA_LOAD);
        endcase
        return w;
    endfunction

    // entry point of each operation
    function automatic logic [UPC_WIDTH-1:0] cia_entry(input logic [2:0] op);
        logic [UPC_WIDTH-1:0] a;
        unique case (op)
            OP_LOAD: a = UA_LOAD;
            OP_ADD:  a = UA_ADD;
            OP_SUB:  a = UA_SUB;
            OP_MUL:  a = UA_MUL0;
            OP_DIV:  a = UA_DIV0;
            OP_CONJ: a = UA_CONJ;
            default: a = UA_CMP;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/complex_integer_alu_unit.sv =====
// ----------------------------------------------------------------------------
// complex_integer_alu_unit
// Signed integer complex accumulator run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one word per operation: s_op selects load, add,
//   subtract, multiply, divide, conjugate or compare (code 7 acts as compare),
//   s_operand_real / s_operand_imag carry the operand (c, d).
//   Result channel (m_*): one word per input word: the accumulator after the
//   operation, an equality flag against the operand and a divide error flag.
//   Load, add, subtract, conjugate and compare commit from their entry
//   step; multiply forms ac, bd, ad and bc and sums them; divide forms
//   the denominator and both numerators, runs the restoring divider (one
//   quotient bit per cycle over the 64-bit numerator magnitude) and writes back.
//   Only one word is in flight: s_ready drops while a program runs and rises
//   again once the result is written to the output register, so a new word
//   may be taken while the previous result still waits on m_ready.
//   If the receiver stalls, the last program step holds until the output
//   register is free; nothing is lost or repeated.
//   Reset (aresetn low, synchronous) clears the accumulator to zero,
//   drops m_valid and raises s_ready.
// ----------------------------------------------------------------------------
module complex_integer_alu_unit
    import cia_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_op,
    input  logic signed [DATA_WIDTH-1:0] s_operand_real,
    input  logic signed [DATA_WIDTH-1:0] s_operand_imag,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_result_real,
    output logic signed [DATA_WIDTH-1:0] m_result_imag,
    output logic                         m_equal_flag,
    output logic                         m_divide_error
);

    cia_ctrl_t ctrl;
    cia_stat_t stat;

    // control: dispatch, step through the program, own both handshakes
    cia_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // datapath: the accumulator doubles as the result word, held until the
    // next program commits, which cannot happen while a result is pending
    cia_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .operand_real (s_operand_real),
        .operand_imag (s_operand_imag),
        .stat         (stat),
        .acc_real     (m_result_real),
        .acc_imag     (m_result_imag),
        .equal_flag   (m_equal_flag),
        .divide_error (m_divide_error)
    );

endmodule

// ===== sv/cia_datapath.sv =====
// ----------------------------------------------------------------------------
// cia_datapath
// Accumulator, operand latch, shared multiplier, wide sums and the two-lane
// restoring divider, all steered by the current control word.
// ----------------------------------------------------------------------------
module cia_datapath
    import cia_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cia_ctrl_t                    ctrl,
    input  logic signed [DATA_WIDTH-1:0] operand_real,
    input  logic signed [DATA_WIDTH-1:0] operand_imag,
    output cia_stat_t                    stat,
    output logic signed [DATA_WIDTH-1:0] acc_real,
    output logic signed [DATA_WIDTH-1:0] acc_imag,
    output logic                         equal_flag,
    output logic                         divide_error
);

    logic signed [DATA_WIDTH-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [DATA_WIDTH-1:0] a_next, b_next;
    logic signed [DATA_WIDTH-1:0] mx, my;
    logic signed [PROD_WIDTH-1:0] prod_reg;
    logic signed [WIDE_WIDTH-1:0] prod_ext;
    logic signed [WIDE_WIDTH-1:0] den_reg, nre_reg, nim_reg;
    logic signed [WIDE_WIDTH-1:0] acc_src, acc_new;
    logic [PROD_WIDTH-1:0]        rre_reg, rim_reg;
    logic                         nre_neg_reg, nim_neg_reg;
    logic                         eq_reg, err_reg;
    logic [WIDE_WIDTH-1:0]        tre, tim;
    logic                         gre, gim;
    logic [DATA_WIDTH-1:0]        qre, qim;

    // multiplier operand select
    always_comb begin
        case (ctrl.uw.mul_sel)
            MS_AC:   begin mx = a_reg; my = c_reg; end
            MS_BD:   begin mx = b_reg; my = d_reg; end
            MS_AD:   begin mx = a_reg; my = d_reg; end
            MS_BC:   begin mx = b_reg; my = c_reg; end
            MS_CC:   begin mx = c_reg; my = c_reg; end
            MS_DD:   begin mx = d_reg; my = d_reg; end
            default: begin mx = a_reg; my = c_reg; end
        endcase
    end

    assign prod_ext = {prod_reg[PROD_WIDTH-1], prod_reg};

    always_comb begin
        case (ctrl.uw.acc_dst)
            AD_DEN:  acc_src = den_reg;
            AD_NRE:  acc_src = nre_reg;
            AD_NIM:  acc_src = nim_reg;
            default: acc_src = den_reg;
        endcase
        case (ctrl.uw.acc_mode)
            AM_ADD:  acc_new = acc_src + prod_ext;
            AM_SUB:  acc_new = acc_src - prod_ext;
            default: acc_new = prod_ext;
        endcase
    end

    // one restoring divider step per lane; quotient bits shift in at the bottom
    assign tre = {rre_reg, nre_reg[PROD_WIDTH-1]};
    assign tim = {rim_reg, nim_reg[PROD_WIDTH-1]};
    assign gre = tre >= den_reg;
    assign gim = tim >= den_reg;

    assign qre = nre_neg_reg ? ({DATA_WIDTH{1'b0}} - nre_reg[DATA_WIDTH-1:0])
                             : nre_reg[DATA_WIDTH-1:0];
    assign qim = nim_neg_reg ? ({DATA_WIDTH{1'b0}} - nim_reg[DATA_WIDTH-1:0])
                             : nim_reg[DATA_WIDTH-1:0];

    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        case (ctrl.uw.wb_sel)
            WB_LOAD: begin a_next = c_reg;         b_next = d_reg;         end
            WB_ADD:  begin a_next = a_reg + c_reg; b_next = b_reg + d_reg; end
            WB_SUB:  begin a_next = a_reg - c_reg; b_next = b_reg - d_reg; end
            WB_CONJ: b_next = -b_reg;
            WB_MUL:  begin
                a_next = nre_reg[DATA_WIDTH-1:0];
                b_next = nim_reg[DATA_WIDTH-1:0];
            end
            WB_DIV:  begin a_next = qre; b_next = qim; end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg <= '0;
            b_reg <= '0;
        end else if (ctrl.commit) begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mx * my;
        if (ctrl.take) begin
            c_reg <= operand_real;
            d_reg <= operand_imag;
        end
        if (ctrl.commit) begin
            eq_reg  <= (a_next == c_reg) && (b_next == d_reg);
            err_reg <= ctrl.uw.wb_sel == WB_ERR;
        end
        if (ctrl.run) begin
            case (ctrl.uw.acc_dst)
                AD_DEN:  den_reg <= acc_new;
                AD_NRE:  nre_reg <= acc_new;
                AD_NIM:  nim_reg <= acc_new;
                default: ;
            endcase
            if (ctrl.uw.div_init) begin
                // take magnitudes, remember signs
                nre_neg_reg <= nre_reg[WIDE_WIDTH-1];
                nim_neg_reg <= nim_reg[WIDE_WIDTH-1];
                nre_reg     <= nre_reg[WIDE_WIDTH-1] ? -nre_reg : nre_reg;
                nim_reg     <= nim_reg[WIDE_WIDTH-1] ? -nim_reg : nim_reg;
                rre_reg     <= '0;
                rim_reg     <= '0;
            end
            if (ctrl.uw.div_step) begin
                rre_reg <= gre ? PROD_WIDTH'(tre - den_reg) : tre[PROD_WIDTH-1:0];
                rim_reg <= gim ? PROD_WIDTH'(tim - den_reg) : tim[PROD_WIDTH-1:0];
                nre_reg <= {1'b0, nre_reg[PROD_WIDTH-2:0], gre};
                nim_reg <= {1'b0, nim_reg[PROD_WIDTH-2:0], gim};
            end
        end
    end

    assign stat.div_zero = (c_reg == '0) && (d_reg == '0);
    assign acc_real      = a_reg;
    assign acc_imag      = b_reg;
    assign equal_flag    = eq_reg;
    assign divide_error  = err_reg;

endmodule

// ===== sv/cia_sequencer.sv =====
// ----------------------------------------------------------------------------
// cia_sequencer
// Microprogram counter, loop counter and handshake control: dispatch on the
// operation code, step through the control store, hand the word over.
// ----------------------------------------------------------------------------
module cia_sequencer
    import cia_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_op,
    output logic       m_valid,
    input  logic       m_ready,
    input  cia_stat_t  stat,
    output cia_ctrl_t  ctrl
);

    logic                 busy_reg, busy_next;
    logic                 m_valid_reg, m_valid_next;
    logic [UPC_WIDTH-1:0] upc_reg, upc_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    cia_uword_t           uw;
    logic                 take, commit;

    assign uw     = cia_ucode(upc_reg);
    assign take   = s_valid && !busy_reg;
    assign commit = busy_reg && (uw.seq == SQ_END) && (!m_valid_reg || m_ready);

    always_comb begin
        busy_next    = busy_reg;
        upc_next     = upc_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (take) begin
            busy_next = 1'b1;
            upc_next  = cia_entry(s_op);
        end else if (busy_reg) begin
            if (uw.div_init) begin
                cnt_next = CNT_WIDTH'(PROD_WIDTH);
            end
            case (uw.seq)
                SQ_END: begin
                    if (commit) begin
                        busy_next    = 1'b0;
                        m_valid_next = 1'b1;
                    end
                end
                SQ_LOOP: begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_WIDTH'(1)) begin
                        upc_next = upc_reg + 1'b1;
                    end
                end
                SQ_JZERO: begin
                    upc_next = stat.div_zero ? uw.target : upc_reg + 1'b1;
                end
                default: upc_next = upc_reg + 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            upc_reg     <= UA_CMP;
            cnt_reg     <= '0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            upc_reg     <= upc_next;
            cnt_reg     <= cnt_next;
        end
    end

    assign s_ready     = !busy_reg;
    assign m_valid     = m_valid_reg;
    assign ctrl.take   = take;
    assign ctrl.run    = busy_reg;
    assign ctrl.commit = commit;
    assign ctrl.uw     = uw;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the complex integer ALU. It drives operation words
// into the input channel and predicts each result word from its own copy of
// the complex accumulator. It checks every result field and runs the traffic
// under three idling patterns on the sender and the receiver.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cia_pkg::*;

    typedef logic signed [DATA_WIDTH-1:0]   data_t;
    // wide enough for ac + bd and c*c + d*d without loss
    typedef logic signed [2*DATA_WIDTH+2:0] wide_t;

    typedef struct {
        data_t re;
        data_t im;
        logic  equal;
        logic  div_err;
    } alu_word_t;

    // spare code 7: behaves as compare only
    localparam logic [2:0] OP_SPARE = 3'd7;

    localparam data_t D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam data_t D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // no word may take longer than a divide plus long stalls; this is far above
    localparam int STALL_LIMIT = 4000;
    // longest program (divide) from acceptance to result, plus margin
    localparam int DRAIN_CYCLES = 100;

    // ------------------------------------------------------------------------
    // Clock, reset and the DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic  aclk           = 1'b0;
    logic  aresetn        = 1'b0;
    logic  s_valid        = 1'b0;
    logic  s_ready;
    logic  [2:0] s_op     = OP_LOAD;
    data_t s_operand_real = '0;
    data_t s_operand_imag = '0;
    logic  m_valid;
    logic  m_ready        = 1'b0;
    data_t m_result_real;
    data_t m_result_imag;
    logic  m_equal_flag;
    logic  m_divide_error;

    always #1 aclk = ~aclk;

    complex_integer_alu_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_operand_real (s_operand_real),
        .s_operand_imag (s_operand_imag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_real  (m_result_real),
        .m_result_imag  (m_result_imag),
        .m_equal_flag   (m_equal_flag),
        .m_divide_error (m_divide_error)
    );

    // ------------------------------------------------------------------------
    // Bench state: the predicted accumulator, the words still owed by the
    // DUT, the idling percentages of the current phase and a few counters.
    // ------------------------------------------------------------------------
    data_t     acc_real = '0;
    data_t     acc_imag = '0;
    alu_word_t owed_words[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int words_accepted  = 0;
    int words_checked   = 0;
    int divides_seen    = 0;
    int div_errors_seen = 0;
    int equal_hits      = 0;
    int mismatches      = 0;
    int quiet_cycles    = 0;

    // ------------------------------------------------------------------------
    // Predictor: apply one operation to the bench accumulator and return the
    // result word the DUT must produce. Divide works on exact wide values and
    // relies on signed division truncating toward zero; every part is then
    // cut back to the data width, which gives the wrap-around.
    // ------------------------------------------------------------------------
    function automatic alu_word_t advance_accumulator(input logic [2:0] op,
                                                      input data_t c,
                                                      input data_t d);
        alu_word_t r;
        data_t     a;
        data_t     b;
        wide_t     wa;
        wide_t     wb;
        wide_t     wc;
        wide_t     wd;
        wide_t     den;
        wide_t     part_re;
        wide_t     part_im;
        a         = acc_real;
        b         = acc_imag;
        wa        = wide_t'(acc_real);
        wb        = wide_t'(acc_imag);
        wc        = wide_t'(c);
        wd        = wide_t'(d);
        r.div_err = 1'b0;
        case (op)
            OP_LOAD: begin
                a = c;
                b = d;
            end
            OP_ADD: begin
                a = acc_real + c;
                b = acc_imag + d;
            end
            OP_SUB: begin
                a = acc_real - c;
                b = acc_imag - d;
            end
            OP_MUL: begin
                // both parts from the old accumulator
                part_re = wa * wc - wb * wd;
                part_im = wa * wd + wb * wc;
                a = part_re[DATA_WIDTH-1:0];
                b = part_im[DATA_WIDTH-1:0];
            end
            OP_DIV: begin
                if (c == '0 && d == '0) begin
                    // zero divisor: hold the accumulator, raise the error
                    r.div_err = 1'b1;
                end else begin
                    den     = wc * wc + wd * wd;
                    part_re = (wa * wc + wb * wd) / den;
                    part_im = (wb * wc - wa * wd) / den;
                    a = part_re[DATA_WIDTH-1:0];
                    b = part_im[DATA_WIDTH-1:0];
                end
            end
            OP_CONJ: begin
                b = -acc_imag;
            end
            default: begin
                // compare only, spare code included
            end
        endcase
        acc_real = a;
        acc_imag = b;
        r.re     = a;
        r.im     = b;
        r.equal  = (a == c) && (b == d);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line per problem, and count it.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Input side monitor. Sample the handshake at the rising edge (values
    // before the edge) and predict the word the DUT owes for it.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            owed_words.push_back(advance_accumulator(s_op, s_operand_real,
                                                     s_operand_imag));
            words_accepted++;
            if (s_op == OP_DIV)
                divides_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall at random by the phase percentage, one assignment per
    // edge, and check each accepted result word against the oldest one owed.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        alu_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_words.size() == 0) begin
                report_mismatch($sformatf("result word with none owed: (%0d, %0d)",
                                          m_result_real, m_result_imag));
            end else begin
                want = owed_words.pop_front();
                words_checked++;
                if (m_result_real !== want.re)
                    report_mismatch($sformatf("result_real got %0d, want %0d",
                                              m_result_real, want.re));
                if (m_result_imag !== want.im)
                    report_mismatch($sformatf("result_imag got %0d, want %0d",
                                              m_result_imag, want.im));
                if (m_equal_flag !== want.equal)
                    report_mismatch($sformatf("equal_flag got %b, want %b",
                                              m_equal_flag, want.equal));
                if (m_divide_error !== want.div_err)
                    report_mismatch($sformatf("divide_error got %b, want %b",
                                              m_divide_error, want.div_err));
                if (want.equal)
                    equal_hits++;
                if (want.div_err)
                    div_errors_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count edges on which no word moves on either channel and
    // abandon the run once the count gets far beyond any legal gap.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender: called in the time step of a rising edge. Idle at random first
    // (valid low), then present the word and hold it until it is taken.
    // Valid is only dropped when a gap is chosen, so it never falls and
    // rises in the same step.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [2:0] op, input data_t re, input data_t im);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_operand_real <= re;
        s_operand_imag <= im;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // operand source: full range, small values, or the awkward corners
    function automatic data_t pick_operand(input int mode);
        data_t v;
        case (mode)
            0:       v = data_t'({$urandom, $urandom});
            1:       v = data_t'($signed($urandom_range(0, 64)) - 32);
            default: begin
                case ($urandom_range(0, 5))
                    0:       v = D_MIN;
                    1:       v = D_MAX;
                    2:       v = '0;
                    3:       v = data_t'(1);
                    4:       v = data_t'(-1);
                    default: v = data_t'({$urandom, $urandom});
                endcase
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // every operation on small values, truncation of a negative quotient
    task automatic test_basic_ops();
        send_word(OP_LOAD,   5, -3);
        send_word(OP_ADD,    2,  7);
        send_word(OP_SUB,    1,  1);
        send_word(OP_MUL,    3,  4);
        send_word(OP_DIV,    3,  4);
        send_word(OP_CONJ,   6, -3);
        send_word(OP_CMP,    6, -3);
        send_word(OP_SPARE,  0,  0);
        send_word(OP_DIV,   -2,  0);
    endtask

    // divide by zero: accumulator held, error raised, compare still valid
    task automatic test_zero_divisor();
        send_word(OP_LOAD, 7, 9);
        send_word(OP_DIV,  0, 0);
        send_word(OP_CMP,  7, 9);
        send_word(OP_LOAD, 0, 0);
        send_word(OP_DIV,  0, 0);
    endtask

    // wrap-around at the extremes of the data range
    task automatic test_wrap_corners();
        send_word(OP_LOAD, D_MAX, D_MIN);
        send_word(OP_ADD,  1, -1);
        send_word(OP_SUB,  1, -1);
        send_word(OP_MUL,  D_MIN, D_MIN);
        send_word(OP_LOAD, 0, D_MIN);
        send_word(OP_CONJ, 0, D_MIN);
        send_word(OP_LOAD, D_MIN, D_MIN);
        send_word(OP_DIV,  D_MIN, D_MIN);
        send_word(OP_LOAD, D_MIN, 0);
        send_word(OP_DIV,  -1, 0);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic. Mostly short well-formed chains (multiply then divide
    // back, load then compare) with random content, the rest plain noise
    // and corner operands.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic(input int idle_in, input int stall_out,
                                       input int word_count);
        int    sent;
        int    mode;
        data_t xr;
        data_t xi;
        data_t yr;
        data_t yi;
        send_idle_pct  = idle_in;
        recv_stall_pct = stall_out;
        sent = 0;
        while (sent < word_count) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    mode = $urandom_range(0, 2);
                    send_word(3'($urandom_range(0, 7)), pick_operand(mode),
                              pick_operand(mode));
                    sent += 1;
                end
                3, 4, 5: begin
                    // multiply then divide by the same value, expect x back unless y is zero
                    xr = pick_operand(1);
                    xi = pick_operand(1);
                    yr = pick_operand(1);
                    yi = pick_operand(1);
                    send_word(OP_LOAD, xr, xi);
                    send_word(OP_MUL,  yr, yi);
                    send_word(OP_DIV,  yr, yi);
                    send_word(OP_CMP,  xr, xi);
                    sent += 4;
                end
                6, 7: begin
                    mode = $urandom_range(0, 1);
                    xr = pick_operand(mode);
                    xi = pick_operand(mode);
                    send_word(OP_LOAD, xr, xi);
                    case ($urandom_range(0, 3))
                        0:       send_word(OP_ADD,  pick_operand(mode), pick_operand(mode));
                        1:       send_word(OP_SUB,  pick_operand(mode), pick_operand(mode));
                        2:       send_word(OP_CONJ, xr, -xi);
                        default: send_word(OP_CMP,  xr, xi);
                    endcase
                    send_word(OP_CMP, xr, xi);
                    sent += 3;
                end
                default: begin
                    send_word(3'($urandom_range(0, 7)), pick_operand(2), pick_operand(2));
                    sent += 1;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Run: one reset, the directed tests, three random phases, then drain.
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct  = 34;
        recv_stall_pct = 47;
        test_basic_ops();
        test_zero_divisor();
        test_wrap_corners();

        test_random_traffic(34, 47, 267);
        test_random_traffic(47, 34, 267);
        test_random_traffic(0, 0, 266);

        // release the channel and wait for every owed word
        s_valid <= 1'b0;
        while (owed_words.size() != 0)
            @(posedge aclk);
        // catch any stray word the DUT might still produce
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d words (%0d divides, %0d by zero) under three idling patterns,",
                 words_accepted, divides_seen, div_errors_seen);
        $display("checked %0d result words, %0d with the equality flag set.",
                 words_checked, equal_hits);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
